/* rtl/lfb_pkg.sv */
// Package for the LED fade and blink controller.
// Holds event codes, register indexes and the request/response structs
// exchanged with the shared arithmetic unit. No dependencies.
package lfb_pkg;

  localparam logic [2:0] KIND_TICK   = 3'd0;
  localparam logic [2:0] KIND_SET    = 3'd1;
  localparam logic [2:0] KIND_FADE   = 3'd2;
  localparam logic [2:0] KIND_BLINK  = 3'd3;
  localparam logic [2:0] KIND_CANCEL = 3'd4;

  localparam logic REG_ON_LEVEL       = 1'b0;
  localparam logic REG_BLINK_INTERVAL = 1'b1;

  localparam logic [7:0]  ON_LEVEL_RST       = 8'd65;
  localparam logic [15:0] BLINK_INTERVAL_RST = 16'd250;

  typedef struct packed {
    logic        start;
    logic [15:0] elapsed;
    logic [15:0] length;
    logic        up;
    logic [7:0]  mag;
  } arith_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] step;
  } arith_rsp_t;

endpackage

/* rtl/lfb_evt_if.sv */
// Event channel interface: valid/ready handshake with the event payload.
// Standalone; no package dependency.
interface lfb_evt_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic        turn_on;
  logic [15:0] ramp_ms;

  modport source (output valid, kind, turn_on, ramp_ms, input ready);
  modport sink   (input valid, kind, turn_on, ramp_ms, output ready);
endinterface

/* rtl/lfb_res_if.sv */
// Result channel interface: valid/ready handshake with the duty result.
// Standalone; no package dependency.
interface lfb_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] duty;
  logic       wanted_on;
  logic       busy_res;

  modport source (output valid, duty, wanted_on, busy_res, input ready);
  modport sink   (input valid, duty, wanted_on, busy_res, output ready);
endinterface

/* rtl/lfb_regs.sv */
// APB-style configuration registers: on_level and blink_interval.
// Depends on lfb_pkg for register indexes and reset values.
module lfb_regs
  import lfb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  on_level_o,
  output logic [15:0] blink_interval_o
);

  logic [7:0]  on_level_q;
  logic [15:0] blink_interval_q;
  logic        wr_en;
  logic        reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_level_q       <= ON_LEVEL_RST;
      blink_interval_q <= BLINK_INTERVAL_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_ON_LEVEL:       on_level_q       <= pwdata[7:0];
        REG_BLINK_INTERVAL: blink_interval_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_ON_LEVEL:       prdata = {24'd0, on_level_q};
      REG_BLINK_INTERVAL: prdata = {16'd0, blink_interval_q};
      default:            prdata = 32'd0;
    endcase
  end

  assign on_level_o       = on_level_q;
  assign blink_interval_o = blink_interval_q;

endmodule

/* rtl/lfb_arith.sv */
// Shared multiply and restoring-divide unit for one fade step.
// Computes round(mag * num / len^2); depends on lfb_pkg for the structs.
module lfb_arith
  import lfb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  arith_req_t req_i,
  output arith_rsp_t rsp_o
);

  localparam logic [2:0] A_IDLE = 3'd0;
  localparam logic [2:0] A_DEN  = 3'd1;
  localparam logic [2:0] A_NUM  = 3'd2;
  localparam logic [2:0] A_PROD = 3'd3;
  localparam logic [2:0] A_INIT = 3'd4;
  localparam logic [2:0] A_DIV  = 3'd5;
  localparam logic [2:0] A_DONE = 3'd6;

  logic [2:0]  state_q, state_d;
  logic [31:0] den_q, den_d;
  logic [31:0] num_q, num_d;
  logic [39:0] prod_q, prod_d;
  logic [41:0] rem_q, rem_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [7:0]  quo_q, quo_d;

  logic [31:0] mul_a;
  logic [16:0] mul_b;
  logic [48:0] mul_p;
  logic [41:0] dvs_shift;
  logic        fits;

  // The single multiplier is shared by the three product steps.
  assign mul_p     = {17'd0, mul_a} * {32'd0, mul_b};
  assign dvs_shift = {9'd0, den_q, 1'b0} << cnt_q;
  assign fits      = rem_q >= dvs_shift;

  always_comb begin
    state_d = state_q;
    den_d   = den_q;
    num_d   = num_q;
    prod_d  = prod_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    mul_a   = 32'd0;
    mul_b   = 17'd0;
    unique case (state_q)
      A_IDLE: begin
        if (req_i.start) begin
          state_d = A_DEN;
        end
      end
      A_DEN: begin
        mul_a   = {16'd0, req_i.length};
        mul_b   = {1'b0, req_i.length};
        den_d   = mul_p[31:0];
        state_d = A_NUM;
      end
      A_NUM: begin
        mul_a = {16'd0, req_i.elapsed};
        if (req_i.up) begin
          mul_b = {1'b0, req_i.elapsed};
        end else begin
          mul_b = {req_i.length, 1'b0} - {1'b0, req_i.elapsed};
        end
        num_d   = mul_p[31:0];
        state_d = A_PROD;
      end
      A_PROD: begin
        mul_a   = num_q;
        mul_b   = {9'd0, req_i.mag};
        prod_d  = mul_p[39:0];
        state_d = A_INIT;
      end
      A_INIT: begin
        // Dividend is 2*mag*num + den for round half up; divisor is 2*den.
        rem_d   = {1'b0, prod_q, 1'b0} + {10'd0, den_q};
        cnt_d   = 3'd7;
        quo_d   = 8'd0;
        state_d = A_DIV;
      end
      A_DIV: begin
        if (fits) begin
          rem_d = rem_q - dvs_shift;
        end
        quo_d = {quo_q[6:0], fits};
        cnt_d = cnt_q - 3'd1;
        if (cnt_q == 3'd0) begin
          state_d = A_DONE;
        end
      end
      A_DONE: begin
        state_d = A_IDLE;
      end
      default: begin
        state_d = A_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q  <= den_d;
    num_q  <= num_d;
    prod_q <= prod_d;
    rem_q  <= rem_d;
    cnt_q  <= cnt_d;
    quo_q  <= quo_d;
  end

  assign rsp_o.done = (state_q == A_DONE);
  assign rsp_o.step = quo_q;

endmodule

/* rtl/led_fade_and_blink_controller_top.sv */
// LED fade and blink controller, top level.
// Depends on lfb_pkg, lfb_evt_if, lfb_res_if, lfb_regs and lfb_arith.
//
// Every accepted event returns one result (duty, wanted state, busy flag).
// The block takes one event at a time. A tick that advances a running fade
// passes through three products on the one shared 32x17 multiplier and a setup
// step, then eight restoring-division steps that yield the eased step one quotient
// bit a cycle, then a done state and the output load. Every other event goes
// straight to the output load, which waits while the output register holds a result
// that is not being taken. A finished result sits in an output register, so a new
// event is accepted while the previous result still waits to be taken.
module led_fade_and_blink_controller_top
  import lfb_pkg::*;
#(
  parameter int unsigned BLINK_STEPS = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lfb_evt_if.sink     evt_i,
  lfb_res_if.source   res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CALC = 2'd1;
  localparam logic [1:0] S_PUSH = 2'd2;
  localparam logic [2:0] STEPS  = 3'(BLINK_STEPS);

  logic [7:0]  on_level;
  logic [15:0] blink_interval;
  arith_req_t  arith_req;
  arith_rsp_t  arith_rsp;

  logic [1:0]  state_q, state_d;
  logic        wanted_q, wanted_d;
  logic [7:0]  level_q, level_d;
  logic [7:0]  rstart_q, rstart_d;
  logic [7:0]  rtarget_q, rtarget_d;
  logic [15:0] relapsed_q, relapsed_d;
  logic [15:0] rlength_q, rlength_d;
  logic        ramping_q, ramping_d;
  logic        blink_q, blink_d;
  logic [2:0]  bcount_q, bcount_d;
  logic [15:0] bwait_q, bwait_d;
  logic        out_valid_q;
  logic [7:0]  duty_q;
  logic        wanted_out_q;
  logic        busy_out_q;

  logic        accept;
  logic        load_out;
  logic        start_calc;
  logic [15:0] elapsed_inc;
  logic [16:0] wait_next;
  logic [7:0]  wanted_lvl;
  logic [7:0]  fade_target;
  logic [9:0]  fade_sum;
  logic [7:0]  fade_lvl;

  lfb_regs u_regs (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .on_level_o       (on_level),
    .blink_interval_o (blink_interval)
  );

  assign arith_req.start   = start_calc;
  assign arith_req.elapsed = relapsed_q;
  assign arith_req.length  = rlength_q;
  assign arith_req.up      = rtarget_q > rstart_q;
  assign arith_req.mag     = (rtarget_q > rstart_q) ? (rtarget_q - rstart_q)
                                                    : (rstart_q - rtarget_q);

  lfb_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (arith_req),
    .rsp_o  (arith_rsp)
  );

  assign evt_i.ready = (state_q == S_IDLE);
  assign accept      = evt_i.valid && (state_q == S_IDLE);
  assign elapsed_inc = (relapsed_q < rlength_q) ? (relapsed_q + 16'd1) : relapsed_q;
  assign wait_next   = {1'b0, bwait_q} + 17'd1;
  assign wanted_lvl  = wanted_q ? on_level : 8'd0;
  assign fade_target = evt_i.turn_on ? on_level : 8'd0;

  // The step never exceeds the distance to the target; the clamp only guards.
  always_comb begin
    if (arith_req.up) begin
      fade_sum = {2'b0, rstart_q} + {2'b0, arith_rsp.step};
    end else begin
      fade_sum = {2'b0, rstart_q} - {2'b0, arith_rsp.step};
    end
    if (fade_sum[9]) begin
      fade_lvl = 8'd0;
    end else if (fade_sum[8]) begin
      fade_lvl = 8'd255;
    end else begin
      fade_lvl = fade_sum[7:0];
    end
  end

  always_comb begin
    state_d    = state_q;
    wanted_d   = wanted_q;
    level_d    = level_q;
    rstart_d   = rstart_q;
    rtarget_d  = rtarget_q;
    relapsed_d = relapsed_q;
    rlength_d  = rlength_q;
    ramping_d  = ramping_q;
    blink_d    = blink_q;
    bcount_d   = bcount_q;
    bwait_d    = bwait_q;
    start_calc = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_PUSH;
          case (evt_i.kind)
            KIND_TICK: begin
              if (ramping_q) begin
                relapsed_d = elapsed_inc;
                if (rlength_q == 16'd0 || elapsed_inc >= rlength_q) begin
                  level_d   = rtarget_q;
                  ramping_d = 1'b0;
                end else begin
                  start_calc = 1'b1;
                  state_d    = S_CALC;
                end
              end else if (blink_q) begin
                if (wait_next < {1'b0, blink_interval}) begin
                  bwait_d = wait_next[15:0];
                end else begin
                  bwait_d = 16'd0;
                  if (bcount_q >= STEPS) begin
                    blink_d = 1'b0;
                    level_d = wanted_lvl;
                  end else begin
                    level_d  = bcount_q[0] ? 8'd0 : on_level;
                    bcount_d = bcount_q + 3'd1;
                  end
                end
              end
            end
            KIND_SET: begin
              wanted_d  = evt_i.turn_on;
              ramping_d = 1'b0;
              if (!blink_q) begin
                level_d = fade_target;
              end
            end
            KIND_FADE: begin
              wanted_d = evt_i.turn_on;
              blink_d  = 1'b0;
              if (evt_i.ramp_ms == 16'd0 || fade_target == level_q) begin
                ramping_d = 1'b0;
                level_d   = fade_target;
              end else begin
                rstart_d   = level_q;
                rtarget_d  = fade_target;
                relapsed_d = 16'd0;
                rlength_d  = evt_i.ramp_ms;
                ramping_d  = 1'b1;
              end
            end
            KIND_BLINK: begin
              ramping_d = 1'b0;
              blink_d   = 1'b1;
              bcount_d  = 3'd0;
              bwait_d   = 16'd0;
            end
            KIND_CANCEL: begin
              blink_d = 1'b0;
              level_d = wanted_lvl;
            end
            default: ;
          endcase
        end
      end
      S_CALC: begin
        if (arith_rsp.done) begin
          level_d = fade_lvl;
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (!out_valid_q || res_o.ready) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wanted_q    <= 1'b0;
      level_q     <= 8'd0;
      rstart_q    <= 8'd0;
      rtarget_q   <= 8'd0;
      relapsed_q  <= 16'd0;
      rlength_q   <= 16'd0;
      ramping_q   <= 1'b0;
      blink_q     <= 1'b0;
      bcount_q    <= 3'd0;
      bwait_q     <= 16'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      wanted_q   <= wanted_d;
      level_q    <= level_d;
      rstart_q   <= rstart_d;
      rtarget_q  <= rtarget_d;
      relapsed_q <= relapsed_d;
      rlength_q  <= rlength_d;
      ramping_q  <= ramping_d;
      blink_q    <= blink_d;
      bcount_q   <= bcount_d;
      bwait_q    <= bwait_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      duty_q       <= level_q;
      wanted_out_q <= wanted_q;
      busy_out_q   <= ramping_q | blink_q;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.duty      = duty_q;
  assign res_o.wanted_on = wanted_out_q;
  assign res_o.busy_res  = busy_out_q;

endmodule

/* tb/sv/led_fade_and_blink_controller_top_tb.sv */
// Self-checking testbench for the LED fade and blink controller top level.
// Depends on lfb_pkg, lfb_evt_if, lfb_res_if and led_fade_and_blink_controller_top;
// a local predictor of the duty, wanted state and busy flag, or a value pinned by a directed row, checks every result.
module led_fade_and_blink_controller_top_tb
  import lfb_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STEPS = 6;
  localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
  localparam logic [2:0] KIND_UNUSED_HI = 3'd7;
  localparam logic [2:0] ADDR_ON_LEVEL = {REG_ON_LEVEL, 2'b00};
  localparam logic [2:0] ADDR_INTERVAL = {REG_BLINK_INTERVAL, 2'b00};
  localparam int DIRECTED_ROWS = 29;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 155;
  localparam int SETTLE_CYCLES = 20;

  typedef struct packed {
    logic [7:0] duty;
    logic       wanted_on;
    logic       busy;
  } led_out_t;

  typedef struct packed {
    logic     pinned;
    led_out_t value;
  } pin_t;

  typedef enum logic {ROW_EVENT, ROW_REG} row_op_e;

  typedef struct packed {
    row_op_e     op;
    logic [2:0]  kind;
    logic        on;
    logic [15:0] ms;
    logic        reg_idx;
    logic [15:0] reg_val;
    logic        pinned;
    led_out_t    want;
  } row_t;

  typedef struct {
    logic        wanted;
    logic [7:0]  level;
    logic [7:0]  ramp_from;
    logic [7:0]  ramp_to;
    logic [15:0] ramp_pos;
    logic [15:0] ramp_len;
    logic        fading;
    logic        blinking;
    logic [2:0]  blink_step;
    logic [15:0] blink_ticks;
  } led_state_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lfb_evt_if evt_bus ();
  lfb_res_if res_bus ();

  led_fade_and_blink_controller_top #(
    .BLINK_STEPS(STEPS)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .evt_i  (evt_bus),
    .res_o  (res_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  led_state_t led;
  logic [7:0]  cfg_on_level;
  logic [15:0] cfg_interval;
  led_out_t    duty_due_q[$];
  pin_t        pinned_q[$];
  row_t        script[DIRECTED_ROWS];
  int          mismatches;
  int          send_gap_pct;
  int          recv_gap_pct;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic logic [7:0] lit_level();
    return led.wanted ? cfg_on_level : 8'd0;
  endfunction

  function automatic void advance_fade();
    longint unsigned e;
    longint unsigned len;
    longint unsigned num;
    longint unsigned den;
    longint unsigned mag;
    longint unsigned q;
    int delta;
    int a;
    int b;
    int lvl;
    if (led.ramp_pos < led.ramp_len) led.ramp_pos = led.ramp_pos + 16'd1;
    e = led.ramp_pos;
    len = led.ramp_len;
    if (len == 0 || e >= len) begin
      led.level = led.ramp_to;
      led.fading = 1'b0;
      return;
    end
    a = led.ramp_to;
    b = led.ramp_from;
    delta = a - b;
    // Rising ramps ease in, falling ramps ease out.
    if (led.ramp_to > led.ramp_from) num = e * e;
    else num = e * (2 * len - e);
    den = len * len;
    if (delta < 0) mag = -delta;
    else mag = delta;
    q = (2 * mag * num + den) / (2 * den);
    if (q > 255) q = 255;
    lvl = (delta < 0) ? b - int'(q) : b + int'(q);
    if (lvl < 0) lvl = 0;
    if (lvl > 255) lvl = 255;
    led.level = lvl[7:0];
  endfunction

  function automatic void advance_blink();
    int unsigned nxt;
    nxt = led.blink_ticks + 1;
    if (nxt < cfg_interval) begin
      led.blink_ticks = nxt[15:0];
      return;
    end
    led.blink_ticks = '0;
    if (led.blink_step >= STEPS) begin
      led.blinking = 1'b0;
      led.level = lit_level();
      return;
    end
    led.level = (led.blink_step[0] == 1'b0) ? cfg_on_level : 8'd0;
    led.blink_step = led.blink_step + 3'd1;
  endfunction

  function automatic led_out_t predict_event(logic [2:0] kind, logic on, logic [15:0] ms);
    logic [7:0] goal;
    led_out_t r;
    case (kind)
      KIND_TICK: begin
        if (led.fading) advance_fade();
        else if (led.blinking) advance_blink();
      end
      KIND_SET: begin
        led.wanted = on;
        led.fading = 1'b0;
        if (!led.blinking) led.level = lit_level();
      end
      KIND_FADE: begin
        led.wanted = on;
        led.blinking = 1'b0;
        goal = on ? cfg_on_level : 8'd0;
        if (ms == 16'd0 || goal == led.level) begin
          led.fading = 1'b0;
          led.level = goal;
        end else begin
          led.ramp_from = led.level;
          led.ramp_to = goal;
          led.ramp_pos = '0;
          led.ramp_len = ms;
          led.fading = 1'b1;
        end
      end
      KIND_BLINK: begin
        led.fading = 1'b0;
        led.blinking = 1'b1;
        led.blink_step = '0;
        led.blink_ticks = '0;
      end
      KIND_CANCEL: begin
        led.blinking = 1'b0;
        led.level = lit_level();
      end
      default: ;
    endcase
    r.duty = led.level;
    r.wanted_on = led.wanted;
    r.busy = led.fading | led.blinking;
    return r;
  endfunction

  function automatic row_t ev(logic [2:0] kind, logic on, logic [15:0] ms);
    row_t r;
    r = '0;
    r.op = ROW_EVENT;
    r.kind = kind;
    r.on = on;
    r.ms = ms;
    return r;
  endfunction

  function automatic row_t evp(logic [2:0] kind, logic on, logic [15:0] ms,
                               logic [7:0] duty, logic won, logic busy);
    row_t r;
    r = ev(kind, on, ms);
    r.pinned = 1'b1;
    r.want = '{duty, won, busy};
    return r;
  endfunction

  function automatic row_t rg(logic idx, logic [15:0] val);
    row_t r;
    r = '0;
    r.op = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  task automatic flag_mismatch(string what, int unsigned want, int unsigned got);
    mismatches++;
    if (mismatches <= 10) $display("mismatch on %s: expected %0d, got %0d", what, want, got);
  endtask

  // Each accepted event is run through the predictor; directed rows may pin the value.
  always @(posedge clk_i) begin : accept_mon
    led_out_t guess;
    pin_t pin;
    if (rst_ni && evt_bus.valid && evt_bus.ready) begin
      guess = predict_event(evt_bus.kind, evt_bus.turn_on, evt_bus.ramp_ms);
      pin = pinned_q.pop_front();
      duty_due_q.push_back(pin.pinned ? pin.value : guess);
    end
  end

  always @(posedge clk_i) begin : result_check
    led_out_t due;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (duty_due_q.size() == 0) begin
        flag_mismatch("result with nothing pending (duty)", 0, res_bus.duty);
      end else begin
        due = duty_due_q.pop_front();
        if (res_bus.duty !== due.duty) flag_mismatch("duty", due.duty, res_bus.duty);
        if (res_bus.wanted_on !== due.wanted_on)
          flag_mismatch("wanted_on", due.wanted_on, res_bus.wanted_on);
        if (res_bus.busy_res !== due.busy) flag_mismatch("busy_res", due.busy, res_bus.busy_res);
      end
    end
  end

  // Result receiver. After 300 transfers it holds off for a long stretch so the
  // block backs up into its event input.
  initial begin : result_sink
    int taken;
    int hold_left;
    logic held;
    taken = 0;
    hold_left = 0;
    held = 1'b0;
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_bus.valid && res_bus.ready) taken++;
      if (hold_left > 0) begin
        hold_left--;
        res_bus.ready <= 1'b0;
      end else if (taken >= 300 && !held) begin
        held = 1'b1;
        hold_left = 400;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= ($urandom_range(0, 99) >= recv_gap_pct);
      end
    end
  end

  task automatic offer_event(input logic [2:0] kind, input logic on, input logic [15:0] ms,
                             input logic pinned, input led_out_t want);
    pin_t pin;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      evt_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    evt_bus.valid <= 1'b1;
    evt_bus.kind <= kind;
    evt_bus.turn_on <= on;
    evt_bus.ramp_ms <= ms;
    pin.pinned = pinned;
    pin.value = want;
    pinned_q.push_back(pin);
    do @(posedge clk_i); while (!evt_bus.ready);
  endtask

  task automatic push_event(input logic [2:0] kind, input logic on, input logic [15:0] ms);
    offer_event(kind, on, ms, 1'b0, '0);
  endtask

  task automatic settle();
    evt_bus.valid <= 1'b0;
    while (duty_due_q.size() != 0 || pinned_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write_reg(input logic idx, input logic [15:0] val);
    logic [31:0] word;
    logic [31:0] mask;
    // Upper bits carry noise; the register keeps only its own width.
    word = {16'($urandom_range(0, 65535)), 16'd0} | {16'd0, val};
    if (idx == REG_ON_LEVEL) begin
      word[15:8] = 8'($urandom_range(0, 255));
      mask = 32'h0000_00FF;
    end else begin
      mask = 32'h0000_FFFF;
    end
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= (idx == REG_ON_LEVEL) ? ADDR_ON_LEVEL : ADDR_INTERVAL;
    pwdata <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_ON_LEVEL) cfg_on_level = word[7:0];
    else cfg_interval = word[15:0];
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if ((prdata & mask) !== (word & mask)) flag_mismatch("register read back", word & mask,
                                                         prdata & mask);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // One well-formed run (a fade or a blink test followed by ticks, among them the odd
  // random event), or a single random event. Events of the unused kinds are not counted.
  task automatic play_scenario(inout int count);
    int pick;
    int n;
    int eff;
    logic on;
    logic [15:0] ms;
    logic [2:0] kind;
    pick = $urandom_range(0, 99);
    on = 1'($urandom_range(0, 1));
    if (pick < 75) begin
      if (pick < 45) begin
        if ($urandom_range(0, 9) == 0) ms = 16'($urandom());
        else ms = 16'($urandom_range(1, 12));
        push_event(KIND_FADE, on, ms);
        n = (ms > 14) ? $urandom_range(1, 10) : ms + $urandom_range(0, 2);
      end else begin
        push_event(KIND_BLINK, on, 16'($urandom()));
        eff = (cfg_interval == 16'd0) ? 1 : cfg_interval;
        n = (cfg_interval <= 16'd8) ? eff * (STEPS + 1) + $urandom_range(0, 3)
                                     : $urandom_range(1, 20);
      end
      count++;
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 19) == 0) begin
          kind = 3'($urandom_range(0, 7));
          push_event(kind, 1'($urandom_range(0, 1)), 16'($urandom()));
          if (kind <= KIND_CANCEL) count++;
        end else begin
          push_event(KIND_TICK, 1'($urandom_range(0, 1)), 16'($urandom()));
          count++;
        end
      end
    end else begin
      kind = 3'($urandom_range(0, 7));
      push_event(kind, on, 16'($urandom()));
      if (kind <= KIND_CANCEL) count++;
    end
  endtask

  initial begin : stimulus
    int count;
    logic [15:0] on_val;
    logic [15:0] iv_val;
    rst_ni <= 1'b0;
    evt_bus.valid <= 1'b0;
    evt_bus.kind <= KIND_TICK;
    evt_bus.turn_on <= 1'b0;
    evt_bus.ramp_ms <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    mismatches = 0;
    led = '{default: '0};
    cfg_on_level = ON_LEVEL_RST;
    cfg_interval = BLINK_INTERVAL_RST;
    send_gap_pct = 11;
    recv_gap_pct = 67;
    script = '{
      evp(KIND_TICK, 1'b0, 16'd0, 8'd0, 1'b0, 1'b0),
      evp(KIND_SET, 1'b1, 16'd0, 8'd65, 1'b1, 1'b0),
      evp(KIND_SET, 1'b0, 16'd0, 8'd0, 1'b0, 1'b0),
      evp(KIND_UNUSED_LO, 1'b1, 16'hFFFF, 8'd0, 1'b0, 1'b0),
      evp(KIND_UNUSED_HI, 1'b1, 16'hFFFF, 8'd0, 1'b0, 1'b0),
      evp(KIND_FADE, 1'b1, 16'd0, 8'd65, 1'b1, 1'b0),
      // Fade to the level already driven completes at once.
      evp(KIND_FADE, 1'b1, 16'd100, 8'd65, 1'b1, 1'b0),
      evp(KIND_FADE, 1'b0, 16'd2, 8'd65, 1'b0, 1'b1),
      ev(KIND_TICK, 1'b0, 16'd0),
      evp(KIND_TICK, 1'b0, 16'd0, 8'd0, 1'b0, 1'b0),
      evp(KIND_FADE, 1'b1, 16'hFFFF, 8'd0, 1'b1, 1'b1),
      ev(KIND_TICK, 1'b0, 16'd0),
      // Set stops a running fade.
      evp(KIND_SET, 1'b1, 16'd0, 8'd65, 1'b1, 1'b0),
      evp(KIND_BLINK, 1'b0, 16'd0, 8'd65, 1'b1, 1'b1),
      // During a blink test a set only records the wanted state.
      evp(KIND_SET, 1'b0, 16'd0, 8'd65, 1'b0, 1'b1),
      evp(KIND_CANCEL, 1'b0, 16'd0, 8'd0, 1'b0, 1'b0),
      evp(KIND_CANCEL, 1'b1, 16'hFFFF, 8'd0, 1'b0, 1'b0),
      rg(REG_ON_LEVEL, 16'd255),
      rg(REG_BLINK_INTERVAL, 16'd1),
      evp(KIND_BLINK, 1'b0, 16'd0, 8'd0, 1'b0, 1'b1),
      ev(KIND_TICK, 1'b0, 16'd0),
      ev(KIND_TICK, 1'b0, 16'd0),
      ev(KIND_TICK, 1'b0, 16'd0),
      ev(KIND_TICK, 1'b0, 16'd0),
      ev(KIND_TICK, 1'b0, 16'd0),
      ev(KIND_TICK, 1'b0, 16'd0),
      ev(KIND_TICK, 1'b0, 16'd0),
      ev(KIND_BLINK, 1'b0, 16'd0),
      // A fade cancels the blink test.
      evp(KIND_FADE, 1'b1, 16'd0, 8'd255, 1'b1, 1'b0)
    };
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      if (script[i].op == ROW_REG) begin
        settle();
        apb_write_reg(script[i].reg_idx, script[i].reg_val);
      end else begin
        offer_event(script[i].kind, script[i].on, script[i].ms, script[i].pinned,
                    script[i].want);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      if (phase < 2) begin
        send_gap_pct = 11;
        recv_gap_pct = 67;
      end else if (phase < 4) begin
        send_gap_pct = 67;
        recv_gap_pct = 11;
      end else begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
      end
      on_val = 16'($urandom_range(0, 255));
      case (phase)
        0: begin
          on_val = 16'd255;
          iv_val = 16'd1;
        end
        1: begin
          on_val = 16'd0;
          iv_val = 16'hFFFF;
        end
        2: iv_val = 16'd0;
        3: begin
          on_val = 16'd1;
          iv_val = 16'd2;
        end
        4: iv_val = 16'($urandom_range(1, 8));
        default: iv_val = 16'd3;
      endcase
      apb_write_reg(REG_ON_LEVEL, on_val);
      apb_write_reg(REG_BLINK_INTERVAL, iv_val);
      count = 0;
      while (count < ITEMS_PER_PHASE) play_scenario(count);
    end

    settle();
    if (mismatches == 0 && duty_due_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

/* filelist.f */
rtl/lfb_pkg.sv
rtl/lfb_evt_if.sv
rtl/lfb_res_if.sv
rtl/lfb_regs.sv
rtl/lfb_arith.sv
rtl/led_fade_and_blink_controller_top.sv
tb/sv/led_fade_and_blink_controller_top_tb.sv
